// ===== rtl/core/sound_level_window_meter_macros.svh =====
// assertion macros for the sound level window meter
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef SOUND_LEVEL_WINDOW_METER_MACROS_SVH
`define SOUND_LEVEL_WINDOW_METER_MACROS_SVH
`ifndef SYNTHESIS
// plain property, sampled on the rising edge, off during reset
`define SLWM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// condition this cycle implies outcome next cycle
`define SLWM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: check failed");
`else
`define SLWM_ASSERT(label, clk, rst, prop)
`define SLWM_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ===== rtl/core/slwm_pkg.sv =====
// shared types and constants of the sound level window meter
// no dependencies
package slwm_pkg;

   localparam int SampleBits     = 12;
   localparam int CfgBits        = 12;
   localparam int LevelBits      = 11;   // window level, sixteenths of a dB
   localparam int LevelFracBits  = 4;
   localparam int OutBits        = 7;
   localparam int ExpBits        = 4;
   localparam int FracBits       = 12;
   localparam int MantBits       = 31;   // q30 mantissa in [1,2)
   localparam int LogBits        = ExpBits + FracBits;
   localparam int OctaveBits     = 23;
   localparam int ProdBits       = LogBits + OctaveBits;
   localparam int LvlShift       = 28;
   localparam int CsrIndexBits   = 2;

   // 16 * 20 * log10(2) in q16
   localparam logic [OctaveBits-1:0] OctaveQ16 = 23'd6313057;
   localparam logic [LevelBits-1:0]  LevelMax  = '1;

   localparam logic [SampleBits-1:0] RejectLimitReset = 12'd3300;
   localparam logic [CfgBits-1:0]    DbOffsetReset    = 12'd128;

   localparam int WindowsPerReportDefault = 12;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_REJECT_LIMIT = 2'd0,
      CSR_DB_OFFSET    = 2'd1
   } slwm_csr_index_type;

   typedef struct packed {
      logic [SampleBits-1:0] sample;
      logic                  window_end;
   } slwm_req_type;

   typedef struct packed {
      logic [OutBits-1:0] min_level;
      logic [OutBits-1:0] max_level;
      logic [OutBits-1:0] mean_level;
   } slwm_rsp_type;

   // closed window handed to the level pipeline
   typedef struct packed {
      logic                  valid;
      logic                  pos;     // peak-to-peak above zero
      logic [SampleBits-1:0] p2p;
   } slwm_win_type;

   // level leaving the level pipeline
   typedef struct packed {
      logic                 valid;
      logic [LevelBits-1:0] level;
   } slwm_lvl_type;

endpackage

// ===== rtl/core/sound_level_window_meter.sv =====
// a closing sample beat's report passes the input, window, level pipeline, snapshot, divide and output registers
// throughput: one sample per cycle; the pipeline holds only while a finished report
//   waits at a stalled output and the next report sits right behind it
// the level path is twelve squaring stages, one multiplier each, plus normalize,
//   scale and clamp stages
// reset (synchronous): registers back to their reset values, window and report cleared
`include "sound_level_window_meter_macros.svh"

// top level of the sound level window meter
// depends on slwm_pkg, slwm_level and sound_level_window_meter_macros.svh
module sound_level_window_meter import slwm_pkg::*; #(
   parameter int WINDOWS_PER_REPORT = WindowsPerReportDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   // sample beats
   input  logic                    req_valid,
   output logic                    req_stall,
   input  slwm_req_type            req_payload,
   // report beats
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output slwm_rsp_type            rsp_payload,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CfgBits-1:0]      csr_data
);

   localparam int IdxBits   = (WINDOWS_PER_REPORT > 1) ? $clog2(WINDOWS_PER_REPORT) : 1;
   localparam int SumBits   = $clog2(WINDOWS_PER_REPORT * (2**LevelBits - 1) + 1);
   localparam int NBits     = SumBits - LevelFracBits;
   // mean by reciprocal multiply, then one correction step
   localparam int DivShift  = 16;
   localparam int MulBits   = DivShift + 1;
   localparam int DivMul    = (2**DivShift) / WINDOWS_PER_REPORT;
   localparam int WBits     = $clog2(WINDOWS_PER_REPORT + 1);
   localparam int RemBits   = NBits + WBits;

   // -------------------------------------------------------------------------
   // pipeline control
   // everything moves together; a hold only happens when a report is ready to
   // leave the divide stage while the output register is full and stalled
   // -------------------------------------------------------------------------
   logic hold;
   logic advance;
   logic div_valid_ff;
   logic rsp_valid_ff;

   assign hold      = rsp_valid_ff && rsp_stall && div_valid_ff;
   assign advance   = !hold;
   assign req_stall = hold;

   // -------------------------------------------------------------------------
   // configuration registers, always ready
   // -------------------------------------------------------------------------
   logic [SampleBits-1:0]      reject_limit_ff;
   logic signed [CfgBits-1:0]  db_offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_limit_ff <= RejectLimitReset;
         db_offset_ff    <= DbOffsetReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REJECT_LIMIT: reject_limit_ff <= csr_data;
            CSR_DB_OFFSET:    db_offset_ff    <= csr_data;
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // input register
   // -------------------------------------------------------------------------
   logic                  in_valid_ff;
   logic [SampleBits-1:0] in_sample_ff;
   logic                  in_close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_sample_ff <= req_payload.sample;
         in_close_ff  <= req_payload.window_end;
      end
   end

   // -------------------------------------------------------------------------
   // window tracking: max and min each checked on every kept sample
   // -------------------------------------------------------------------------
   logic [SampleBits-1:0]   win_high_ff;
   logic [SampleBits-1:0]   win_low_ff;
   logic                    keep;
   logic [SampleBits-1:0]   high_upd;
   logic [SampleBits-1:0]   low_upd;
   logic signed [SampleBits:0] p2p;
   slwm_win_type            win_in;
   slwm_win_type            win_ff;

   assign keep     = in_sample_ff < reject_limit_ff;
   assign high_upd = (keep && (in_sample_ff > win_high_ff)) ? in_sample_ff : win_high_ff;
   assign low_upd  = (keep && (in_sample_ff < win_low_ff))  ? in_sample_ff : win_low_ff;
   // the closing sample is folded in before peak-to-peak is taken
   assign p2p      = $signed({1'b0, high_upd}) - $signed({1'b0, low_upd});

   assign win_in.valid = in_valid_ff && in_close_ff;
   assign win_in.pos   = p2p > 0;
   assign win_in.p2p   = p2p[SampleBits-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_high_ff <= '0;
         win_low_ff  <= RejectLimitReset;
      end else if (advance && in_valid_ff) begin
         if (in_close_ff) begin
            // fresh window starts from the current reject limit
            win_high_ff <= '0;
            win_low_ff  <= reject_limit_ff;
         end else begin
            win_high_ff <= high_upd;
            win_low_ff  <= low_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.valid <= 1'b0;
      end else if (advance) begin
         win_ff.valid <= win_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff.pos <= win_in.pos;
         win_ff.p2p <= win_in.p2p;
      end
   end

   // -------------------------------------------------------------------------
   // level pipeline
   // -------------------------------------------------------------------------
   slwm_lvl_type lvl;

   slwm_level u_level (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .db_offset (db_offset_ff),
      .win_in    (win_ff),
      .lvl_out   (lvl)
   );

   // -------------------------------------------------------------------------
   // report statistics
   // -------------------------------------------------------------------------
   logic [IdxBits-1:0]   window_index_ff;
   logic [LevelBits-1:0] report_low_ff;
   logic [LevelBits-1:0] report_high_ff;
   logic [SumBits-1:0]   level_sum_ff;
   logic [LevelBits-1:0] low_new;
   logic [LevelBits-1:0] high_new;
   logic [SumBits-1:0]   sum_new;
   logic                 last_window;

   assign low_new     = (lvl.level < report_low_ff)  ? lvl.level : report_low_ff;
   assign high_new    = (lvl.level > report_high_ff) ? lvl.level : report_high_ff;
   assign sum_new     = level_sum_ff + SumBits'(lvl.level);
   assign last_window = window_index_ff == IdxBits'(WINDOWS_PER_REPORT - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_index_ff <= '0;
         report_low_ff   <= LevelMax;
         report_high_ff  <= '0;
         level_sum_ff    <= '0;
      end else if (advance && lvl.valid) begin
         if (last_window) begin
            window_index_ff <= '0;
            report_low_ff   <= LevelMax;
            report_high_ff  <= '0;
            level_sum_ff    <= '0;
         end else begin
            window_index_ff <= window_index_ff + IdxBits'(1);
            report_low_ff   <= low_new;
            report_high_ff  <= high_new;
            level_sum_ff    <= sum_new;
         end
      end
   end

   // snapshot of a finished report, levels truncated to whole dB
   logic               rep_valid_ff;
   logic [OutBits-1:0] rep_low_ff;
   logic [OutBits-1:0] rep_high_ff;
   logic [NBits-1:0]   rep_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_valid_ff <= 1'b0;
      end else if (advance) begin
         rep_valid_ff <= lvl.valid && last_window;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rep_low_ff  <= low_new[LevelBits-1:LevelFracBits];
         rep_high_ff <= high_new[LevelBits-1:LevelFracBits];
         rep_n_ff    <= sum_new[SumBits-1:LevelFracBits];
      end
   end

   // -------------------------------------------------------------------------
   // mean: estimate quotient by reciprocal, at most one low
   // -------------------------------------------------------------------------
   logic [NBits+MulBits-1:0] div_prod;
   logic [NBits-1:0]         div_q_ff;
   logic [NBits-1:0]         div_n_ff;
   logic [OutBits-1:0]       div_low_ff;
   logic [OutBits-1:0]       div_high_ff;

   assign div_prod = {{MulBits{1'b0}}, rep_n_ff} * {{NBits{1'b0}}, MulBits'(DivMul)};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= 1'b0;
      end else if (advance) begin
         div_valid_ff <= rep_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_q_ff    <= div_prod[DivShift +: NBits];
         div_n_ff    <= rep_n_ff;
         div_low_ff  <= rep_low_ff;
         div_high_ff <= rep_high_ff;
      end
   end

   // correction step
   logic [RemBits-1:0] rem;
   logic [NBits-1:0]   mean_q;

   assign rem    = RemBits'(div_n_ff)
                   - ({{WBits{1'b0}}, div_q_ff} * {{NBits{1'b0}}, WBits'(WINDOWS_PER_REPORT)});
   assign mean_q = (rem >= RemBits'(WINDOWS_PER_REPORT)) ? div_q_ff + NBits'(1) : div_q_ff;

   // -------------------------------------------------------------------------
   // output register
   // -------------------------------------------------------------------------
   slwm_rsp_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && div_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && div_valid_ff) begin
         rsp_payload_ff.min_level  <= div_low_ff;
         rsp_payload_ff.max_level  <= div_high_ff;
         rsp_payload_ff.mean_level <= OutBits'(mean_q);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // -------------------------------------------------------------------------
   // checks
   // -------------------------------------------------------------------------
   `SLWM_ASSERT(a_report_order, clock, reset, (window_index_ff != '0) |-> (report_low_ff <= report_high_ff))
   `SLWM_ASSERT(a_sum_bound, clock, reset, 32'(level_sum_ff) <= 32'(window_index_ff) * 32'(LevelMax))
   `SLWM_ASSERT(a_mean_between, clock, reset, rsp_valid |-> (rsp_payload.min_level <= rsp_payload.mean_level && rsp_payload.mean_level <= rsp_payload.max_level))
   `SLWM_ASSERT_NEXT(a_hold_keeps, clock, reset, req_stall, rsp_valid && div_valid_ff)

endmodule

// ===== rtl/core/slwm_level.sv =====
// level pipeline: peak-to-peak value to level in sixteenths of a dB
// depends on slwm_pkg
module slwm_level import slwm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic signed [CfgBits-1:0] db_offset,
   input  slwm_win_type              win_in,
   output slwm_lvl_type              lvl_out
);

   // normalize
   logic [ExpBits-1:0]  lead_exp;
   logic [MantBits-1:0] mant_in;

   always_comb begin
      lead_exp = '0;
      for (int i = 0; i < SampleBits; i++) begin
         if (win_in.p2p[i]) begin
            lead_exp = ExpBits'(i);
         end
      end
   end

   assign mant_in = {{(MantBits-SampleBits){1'b0}}, win_in.p2p}
                    << (5'(MantBits-1) - 5'(lead_exp));

   // squaring stages, stage 0 holds the normalized value
   logic [MantBits-1:0] sq_mant_ff [FracBits+1];
   logic [FracBits-1:0] sq_frac_ff [FracBits+1];
   logic [ExpBits-1:0]  sq_exp_ff  [FracBits+1];
   logic                sq_pos_ff  [FracBits+1];
   logic [FracBits:0]   sq_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         sq_valid_ff[0] <= win_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_mant_ff[0] <= mant_in;
         sq_frac_ff[0] <= '0;
         sq_exp_ff[0]  <= lead_exp;
         sq_pos_ff[0]  <= win_in.pos;
      end
   end

   for (genvar k = 1; k <= FracBits; k++) begin : g_sq
      logic [2*MantBits-1:0] square;
      logic [MantBits:0]     scaled;
      logic [MantBits-1:0]   mant_next;

      assign square    = {{MantBits{1'b0}}, sq_mant_ff[k-1]}
                         * {{MantBits{1'b0}}, sq_mant_ff[k-1]};
      assign scaled    = square[2*MantBits-1:MantBits-1];
      // square reached two: one fraction bit, renormalize
      assign mant_next = scaled[MantBits] ? scaled[MantBits:1] : scaled[MantBits-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (advance) begin
            sq_valid_ff[k] <= sq_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sq_mant_ff[k] <= mant_next;
            sq_frac_ff[k] <= {sq_frac_ff[k-1][FracBits-2:0], scaled[MantBits]};
            sq_exp_ff[k]  <= sq_exp_ff[k-1];
            sq_pos_ff[k]  <= sq_pos_ff[k-1];
         end
      end
   end

   // log2 times the dB scale
   logic [LogBits-1:0]  log_word;
   logic [ProdBits-1:0] mul_prod_ff;
   logic                mul_pos_ff;
   logic                mul_valid_ff;

   assign log_word = {sq_exp_ff[FracBits], sq_frac_ff[FracBits]};

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= sq_valid_ff[FracBits];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_prod_ff <= {{OctaveBits{1'b0}}, log_word} * {{LogBits{1'b0}}, OctaveQ16};
         mul_pos_ff  <= sq_pos_ff[FracBits];
      end
   end

   // round, add offset, clamp
   logic [ProdBits-1:0]       rounded;
   logic [LevelBits-1:0]      lvl_round;
   logic signed [CfgBits:0]   lvl_sum;
   logic [LevelBits-1:0]      level_in;
   logic [LevelBits-1:0]      level_ff;
   logic                      level_valid_ff;

   assign rounded   = mul_prod_ff + (ProdBits'(1) << (LvlShift - 1));
   assign lvl_round = rounded[ProdBits-1:LvlShift];
   assign lvl_sum   = $signed({2'b00, lvl_round}) + $signed({db_offset[CfgBits-1], db_offset});

   always_comb begin
      priority if (!mul_pos_ff) begin
         level_in = '0;
      end else if (lvl_sum < 0) begin
         level_in = '0;
      end else if (lvl_sum > $signed({2'b00, LevelMax})) begin
         level_in = LevelMax;
      end else begin
         level_in = lvl_sum[LevelBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_valid_ff <= 1'b0;
      end else if (advance) begin
         level_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
      end
   end

   assign lvl_out.valid = level_valid_ff;
   assign lvl_out.level = level_ff;

endmodule

// ===== bench/sound_level_window_meter_tb.sv =====
// self-checking bench for the sound level window meter: sample beats in, report beats out
// depends on slwm_pkg and the sound_level_window_meter rtl; nothing else is read
module sound_level_window_meter_tb;
   import slwm_pkg::*;

   localparam int WindowsPerReport = WindowsPerReportDefault;
   localparam int LevelLatency     = 19;       // closing beat to report beat
   localparam int RandomBeats      = 1650;
   localparam int CycleLimit       = 300000;

   // register indexes the block has no register for
   localparam logic [CsrIndexBits-1:0] CsrSpareLow  = 2'd2;
   localparam logic [CsrIndexBits-1:0] CsrSpareHigh = 2'd3;

   // how the samples of one window are drawn
   typedef enum int {
      MIX_FULL_RANGE,
      MIX_BURST,
      MIX_FLAT,
      MIX_OVER_LIMIT
   } sample_mix_type;

   // rows of the directed table
   typedef enum int {
      ROW_BEAT,
      ROW_CSR
   } plan_kind_type;

   typedef struct {
      plan_kind_type             kind;
      slwm_req_type              beat;
      logic [CsrIndexBits-1:0]   index;
      logic [CfgBits-1:0]        data;
      bit                        typed;    // report value written out by hand
      slwm_rsp_type              want;
   } plan_row_type;

   // ------------------------------------------------------------------
   // clock, reset and the block's inputs, all known from time zero
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   slwm_req_type            req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   slwm_rsp_type            rsp_payload;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index   = '0;
   logic [CfgBits-1:0]      csr_data    = '0;

   sound_level_window_meter #(
      .WINDOWS_PER_REPORT(WindowsPerReport)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // ------------------------------------------------------------------
   // bench bookkeeping
   // ------------------------------------------------------------------
   slwm_rsp_type report_q[$];      // reports owed by the block, oldest first
   int  bad_count    = 0;
   int  samples_sent = 0;
   int  reports_seen = 0;
   int  csr_writes   = 0;
   int  cycle_count  = 0;
   bit  quiet        = 1'b0;       // last stretch: no gaps, no stalls
   int  idle_pct     = 25;         // chance of a gap before a sample beat
   bit  beat_typed   = 1'b0;       // travels with the beat on the wire
   slwm_rsp_type beat_want = '0;

   // ------------------------------------------------------------------
   // level predictor: its own copy of registers and window/report state
   // ------------------------------------------------------------------
   logic [SampleBits-1:0]       reject_cfg;
   logic signed [CfgBits-1:0]   offset_cfg;
   logic [SampleBits-1:0]       win_top;
   logic [SampleBits-1:0]       win_floor;
   int                          win_count;
   logic [LevelBits-1:0]        rpt_low;
   logic [LevelBits-1:0]        rpt_high;
   int                          rpt_sum;

   task automatic clear_meter();
      reject_cfg = RejectLimitReset;
      offset_cfg = DbOffsetReset;
      win_top    = '0;
      win_floor  = RejectLimitReset;
      win_count  = 0;
      rpt_low    = LevelMax;
      rpt_high   = '0;
      rpt_sum    = 0;
   endtask

   // 20*log10(p2p) in sixteenths of a dB plus offset, clamped
   // log2 fraction comes from twelve rounds of squaring a q30 mantissa
   function automatic logic [LevelBits-1:0] level_sixteenths(input int p2p);
      int unsigned          msb;
      longint unsigned      mant;
      longint unsigned      log_q12;
      longint unsigned      scaled;
      longint               with_offset;
      logic [FracBits-1:0]  frac;
      if (p2p <= 0) return '0;
      msb = 0;
      for (int b = 0; b < 31; b++)
         if (p2p[b]) msb = b;
      mant = longint'(p2p) << (30 - msb);
      frac = '0;
      for (int i = 0; i < FracBits; i++) begin
         mant = (mant * mant) >> 30;
         frac = {frac[FracBits-2:0], 1'b0};
         if (mant >= (64'd1 << 31)) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      log_q12 = (longint'(msb) << FracBits) | longint'(frac);
      scaled = (log_q12 * OctaveQ16 + (64'd1 << 27)) >> LvlShift;
      with_offset = longint'(scaled) + longint'(offset_cfg);
      if (with_offset < 0) return '0;
      if (with_offset > longint'(LevelMax)) return LevelMax;
      return with_offset[LevelBits-1:0];
   endfunction

   // fold one accepted sample beat into the window, close it if marked
   task automatic fold_sample(input slwm_req_type beat, output bit done,
                              output slwm_rsp_type rpt);
      logic [LevelBits-1:0] lvl;
      done = 1'b0;
      rpt  = '0;
      // max and min are tracked independently, every kept sample touches both
      if (beat.sample < reject_cfg) begin
         if (beat.sample > win_top)   win_top   = beat.sample;
         if (beat.sample < win_floor) win_floor = beat.sample;
      end
      if (beat.window_end) begin
         lvl = level_sixteenths(int'(win_top) - int'(win_floor));
         win_top   = '0;
         win_floor = reject_cfg;
         if (lvl < rpt_low)  rpt_low  = lvl;
         if (lvl > rpt_high) rpt_high = lvl;
         rpt_sum = rpt_sum + int'(lvl);
         if (win_count == WindowsPerReport - 1) begin
            rpt.min_level  = OutBits'(rpt_low >> LevelFracBits);
            rpt.max_level  = OutBits'(rpt_high >> LevelFracBits);
            rpt.mean_level = OutBits'(rpt_sum / (16 * WindowsPerReport));
            done      = 1'b1;
            win_count = 0;
            rpt_low   = LevelMax;
            rpt_high  = '0;
            rpt_sum   = 0;
         end else begin
            win_count = win_count + 1;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in report %0d, %s: got %0d, want %0d",
               reports_seen, what, got, want);
      bad_count++;
   endtask

   // ------------------------------------------------------------------
   // monitor: everything is sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      bit           made;
      slwm_rsp_type rpt;
      slwm_rsp_type owed;
      if (reset) begin
         clear_meter();
      end else begin
         // register beats land in the predictor at the same edge as in the block
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               CSR_REJECT_LIMIT: reject_cfg = csr_data;
               CSR_DB_OFFSET:    offset_cfg = csr_data;
               default:          ;   // no register there, write dropped
            endcase
         end
         // sample beat accepted: predict, and owe a report on the close of a report
         if (req_valid && !req_stall) begin
            fold_sample(req_payload, made, rpt);
            if (made) report_q.push_back(beat_typed ? beat_want : rpt);
         end
         // report beat accepted: compare against the oldest owed report
         if (rsp_valid && !rsp_stall) begin
            reports_seen++;
            if (report_q.size() == 0) begin
               report_mismatch("report with none due", 1, 0);
            end else begin
               owed = report_q.pop_front();
               if (rsp_payload.min_level !== owed.min_level)
                  report_mismatch("min_level", rsp_payload.min_level, owed.min_level);
               if (rsp_payload.max_level !== owed.max_level)
                  report_mismatch("max_level", rsp_payload.max_level, owed.max_level);
               if (rsp_payload.mean_level !== owed.mean_level)
                  report_mismatch("mean_level", rsp_payload.mean_level, owed.mean_level);
            end
         end
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("run stopped after %0d cycles, %0d reports still owed",
                  cycle_count, report_q.size());
         $display("sound_level_window_meter_tb NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // report side back-pressure: stall bursts, rate drifts
   // ------------------------------------------------------------------
   initial begin : rsp_pressure
      int stall_pct;
      int burst;
      stall_pct = 0;
      forever begin
         @(negedge clock);
         // every so often pick a new stall rate, zero included for clean stretches
         if ($urandom_range(0, 63) == 0) stall_pct = $urandom_range(0, 2) * 15;
         if (!quiet && !reset && $urandom_range(0, 99) < stall_pct) begin
            burst = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // drivers: inputs move at the falling edge only
   // ------------------------------------------------------------------
   // one sample beat, maybe after an idle gap; returns at the accepting edge
   task automatic send_beat(input slwm_req_type beat, input bit typed,
                            input slwm_rsp_type want);
      int gap;
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= beat;
      beat_typed  <= typed;
      beat_want   <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   task automatic write_csr(input logic [CsrIndexBits-1:0] idx,
                            input logic [CfgBits-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // let every owed report out, then let the level pipeline empty
   // (closed windows that owe no report may still be in flight)
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (report_q.size() != 0) @(posedge clock);
      repeat (LevelLatency + 10) @(posedge clock);
   endtask

   function automatic logic [SampleBits-1:0] draw_sample(input sample_mix_type mix,
                                                         input int centre, input int spread);
      int v;
      case (mix)
         MIX_FULL_RANGE: v = int'($urandom_range(0, 4095));
         MIX_BURST:      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
         MIX_FLAT:       v = centre;
         default:        v = int'(reject_cfg) + int'($urandom_range(0, 40)) - 2;
      endcase
      if (v < 0)    v = 0;
      if (v > 4095) v = 4095;
      return v[SampleBits-1:0];
   endfunction

   // directed table rows
   function automatic plan_row_type beat_row(input int smp, input bit close);
      plan_row_type r;
      r = '{kind: ROW_BEAT, beat: '0, index: '0, data: '0, typed: 1'b0, want: '0};
      r.beat.sample     = smp[SampleBits-1:0];
      r.beat.window_end = close;
      return r;
   endfunction

   function automatic plan_row_type closing_row(input int smp, input slwm_rsp_type want);
      plan_row_type r;
      r = beat_row(smp, 1'b1);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CsrIndexBits-1:0] idx,
                                            input logic [CfgBits-1:0] data);
      plan_row_type r;
      r = '{kind: ROW_CSR, beat: '0, index: idx, data: data, typed: 1'b0, want: '0};
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type  plan[$];
      bit            was_beat;
      slwm_req_type  beat;
      sample_mix_type mix;
      int            win_left;
      int            centre;
      int            spread;
      int            phase_len;
      int            target;
      logic [CfgBits-1:0] pick;

      // report after reset: twelve windows that are empty (all samples at or
      // over the limit) or flat (one kept sample), so every level is zero
      plan.push_back(beat_row(3300, 1));    // exactly at the limit, tossed
      plan.push_back(beat_row(4095, 1));
      plan.push_back(beat_row(0, 1));       // flat window, no offset added
      plan.push_back(beat_row(3299, 1));    // last value under the limit
      plan.push_back(beat_row(3301, 1));
      plan.push_back(beat_row(2048, 1));
      plan.push_back(beat_row(3300, 1));
      plan.push_back(beat_row(4095, 1));
      plan.push_back(beat_row(1, 1));
      plan.push_back(beat_row(3300, 1));
      plan.push_back(beat_row(4095, 1));
      plan.push_back(closing_row(3300,
         '{min_level: 7'd0, max_level: 7'd0, mean_level: 7'd0}));
      // writes to indexes with no register must change nothing
      plan.push_back(csr_row(CsrSpareLow, 12'hFFF));
      plan.push_back(csr_row(CsrSpareHigh, 12'h000));
      // widest limit, largest offset: the one live window saturates
      plan.push_back(csr_row(CSR_REJECT_LIMIT, 12'd4095));
      plan.push_back(csr_row(CSR_DB_OFFSET, 12'h7FF));
      plan.push_back(beat_row(0, 0));
      plan.push_back(beat_row(4094, 1));    // full swing, level clamps at 2047
      plan.push_back(beat_row(4095, 1));    // at the new limit: empty window
      plan.push_back(beat_row(4094, 1));
      plan.push_back(beat_row(0, 1));
      plan.push_back(beat_row(1, 1));
      plan.push_back(beat_row(2048, 1));
      plan.push_back(beat_row(2730, 1));
      plan.push_back(beat_row(1365, 1));
      plan.push_back(beat_row(4094, 1));
      plan.push_back(beat_row(12, 1));
      plan.push_back(beat_row(3000, 1));
      // one saturated window over twelve: mean is 2047 / 192
      plan.push_back(closing_row(7,
         '{min_level: 7'd0, max_level: 7'd127, mean_level: 7'd10}));

      // reset held from time zero, released at a falling edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed table
      was_beat = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            if (was_beat) settle();
            write_csr(plan[i].index, plan[i].data);
            was_beat = 1'b0;
         end else begin
            send_beat(plan[i].beat, plan[i].typed, plan[i].want);
            was_beat = 1'b1;
         end
      end

      // random phases: registers change only once the block has drained;
      // phase ends fall mid window too, so the open window sees the new limit
      target   = samples_sent + RandomBeats;
      win_left = 0;
      mix      = MIX_FULL_RANGE;
      centre   = 0;
      spread   = 1;
      while (samples_sent < target) begin
         settle();
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0:       pick = 12'd0;          // every sample tossed
               1:       pick = 12'd4095;
               2:       pick = RejectLimitReset;
               default: pick = 12'($urandom_range(1, 4095));
            endcase
            write_csr(CSR_REJECT_LIMIT, pick);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0:       pick = 12'h800;        // most negative offset, clamps to zero
               1:       pick = 12'h7FF;
               2:       pick = 12'h000;
               default: pick = 12'($urandom());
            endcase
            write_csr(CSR_DB_OFFSET, pick);
         end
         if ($urandom_range(0, 7) == 0)
            write_csr($urandom_range(0, 1) ? CsrSpareLow : CsrSpareHigh, 12'($urandom()));

         idle_pct  = $urandom_range(0, 2) * 20;
         phase_len = $urandom_range(40, 160);
         repeat (phase_len) begin
            if (win_left == 0) begin
               // short windows keep reports coming; now and then a long one
               win_left = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(1, 5);
               mix    = sample_mix_type'($urandom_range(0, 3));
               centre = (reject_cfg == 0) ? 0 : $urandom_range(0, int'(reject_cfg) - 1);
               spread = 1 << $urandom_range(0, 11);
            end
            beat.sample     = draw_sample(mix, centre, spread);
            beat.window_end = (win_left == 1);
            win_left--;
            send_beat(beat, 1'b0, '0);
         end
         // last stretch of the run goes without gaps or stalls
         if (samples_sent >= target - RandomBeats / 8) quiet = 1'b1;
      end

      quiet = 1'b1;
      settle();
      $display("sent %0d sample beats and %0d register writes; checked %0d reports",
               samples_sent, csr_writes, reports_seen);
      $display("level mismatches: %0d", bad_count);
      if (bad_count == 0) begin
         $display("sound_level_window_meter_tb OK");
      end else begin
         $display("sound_level_window_meter_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sound_level_window_meter.f =====
+incdir+rtl/core
rtl/core/slwm_pkg.sv
rtl/core/slwm_level.sv
rtl/core/sound_level_window_meter.sv
bench/sound_level_window_meter_tb.sv
